// ----- hw/rtl/apt_pkg.sv -----
// ----------------------------------------------------------------------------
// apt_pkg: shared types and constants of the affine point transform
// Fixed-point formats, configuration layout and register indexes.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int COORD_W    = 24;  // signed Q16.8 coordinates and shifts
  localparam int COEFF_W    = 16;  // signed Q2.14 coefficients
  localparam int FRAC_EXTRA = COEFF_W - 2;
  localparam int PROD_W     = COEFF_W + COORD_W;
  localparam int RND_W      = PROD_W - FRAC_EXTRA + 1;
  localparam int SUM_W      = RND_W + 2;
  localparam int ROW_W      = 3 * COEFF_W;
  localparam int CFG_DATA_W = (ROW_W > COORD_W) ? ROW_W : COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int PIPE_DEPTH = 5;   // input, product, round, sum, saturate
  localparam int ROUND_HALF = 1 << (FRAC_EXTRA - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [RND_W-1:0]   rnd_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam coord_t COORD_MAX = coord_t'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam coord_t COORD_MIN = coord_t'(-(64'sd1 <<< (COORD_W - 1)));

  localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(1) << FRAC_EXTRA;
  localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(1) << (COEFF_W + FRAC_EXTRA);
  localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(1) << (2 * COEFF_W + FRAC_EXTRA);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0,
    CFG_ROW1,
    CFG_ROW2,
    CFG_SHIFT_X,
    CFG_SHIFT_Y,
    CFG_SHIFT_Z,
    CFG_DISPLACE
  } cfg_idx_e;

  // coeff[0] sits in the low bits, as in the register layout
  typedef struct packed {
    coeff_t [2:0] coeff;
    coord_t       shift;
  } row_cfg_t;

  typedef struct packed {
    row_cfg_t [2:0] row;
    logic           displace;
  } cfg_t;

endpackage

// ----- hw/rtl/apt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// apt_cfg_regs: configuration registers
// Holds the 3x4 matrix and the displacement enable; write only.
// ----------------------------------------------------------------------------
module apt_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [apt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [apt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output apt_pkg::cfg_t                       cfg_o
);

  apt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row[0].coeff <= apt_pkg::ROW0_RESET;
      cfg_q.row[1].coeff <= apt_pkg::ROW1_RESET;
      cfg_q.row[2].coeff <= apt_pkg::ROW2_RESET;
      cfg_q.row[0].shift <= '0;
      cfg_q.row[1].shift <= '0;
      cfg_q.row[2].shift <= '0;
      cfg_q.displace     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apt_pkg::CFG_ROW0:     cfg_q.row[0].coeff <= cfg_wdata_i[apt_pkg::ROW_W-1:0];
        apt_pkg::CFG_ROW1:     cfg_q.row[1].coeff <= cfg_wdata_i[apt_pkg::ROW_W-1:0];
        apt_pkg::CFG_ROW2:     cfg_q.row[2].coeff <= cfg_wdata_i[apt_pkg::ROW_W-1:0];
        apt_pkg::CFG_SHIFT_X:  cfg_q.row[0].shift <= cfg_wdata_i[apt_pkg::COORD_W-1:0];
        apt_pkg::CFG_SHIFT_Y:  cfg_q.row[1].shift <= cfg_wdata_i[apt_pkg::COORD_W-1:0];
        apt_pkg::CFG_SHIFT_Z:  cfg_q.row[2].shift <= cfg_wdata_i[apt_pkg::COORD_W-1:0];
        apt_pkg::CFG_DISPLACE: cfg_q.displace     <= cfg_wdata_i[0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/apt_row_pipe.sv -----
// ----------------------------------------------------------------------------
// apt_row_pipe: one output coordinate
// Multiply, round, sum with translation and saturate, one register each.
// ----------------------------------------------------------------------------
module apt_row_pipe (
  input  logic                  clk_i,
  input  apt_pkg::row_cfg_t     row_cfg_i,
  input  logic                  displace_i,
  input  apt_pkg::coord_t [2:0] point_i,
  output apt_pkg::coord_t       q_o,
  output logic                  sat_o
);

  apt_pkg::prod_t [2:0]        prod_q;
  apt_pkg::rnd_t  [2:0]        rnd_d, rnd_q;
  logic signed [apt_pkg::PROD_W:0] biased [3];
  apt_pkg::coord_t             shift_term;
  apt_pkg::sum_t               sum_d, sum_q;
  apt_pkg::coord_t             q_d, q_q;
  logic                        sat_d, sat_q;

  // products: one multiplier per term
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= apt_pkg::prod_t'(row_cfg_i.coeff[k]) * apt_pkg::prod_t'(point_i[k]);
    end
  end

  // round to nearest, ties toward +inf: add half an LSB, then floor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      biased[k] = {prod_q[k][apt_pkg::PROD_W-1], prod_q[k]}
                + (apt_pkg::PROD_W + 1)'(apt_pkg::ROUND_HALF);
      rnd_d[k]  = apt_pkg::rnd_t'(biased[k] >>> apt_pkg::FRAC_EXTRA);
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
  end

  always_comb begin
    shift_term = displace_i ? row_cfg_i.shift : apt_pkg::coord_t'(0);
    sum_d = apt_pkg::sum_t'(rnd_q[0]) + apt_pkg::sum_t'(rnd_q[1])
          + apt_pkg::sum_t'(rnd_q[2]) + apt_pkg::sum_t'(shift_term);
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  always_comb begin
    if (sum_q > apt_pkg::sum_t'(apt_pkg::COORD_MAX)) begin
      q_d   = apt_pkg::COORD_MAX;
      sat_d = 1'b1;
    end else if (sum_q < apt_pkg::sum_t'(apt_pkg::COORD_MIN)) begin
      q_d   = apt_pkg::COORD_MIN;
      sat_d = 1'b1;
    end else begin
      q_d   = apt_pkg::coord_t'(sum_q);
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    sat_q <= sat_d;
  end

  assign q_o   = q_q;
  assign sat_o = sat_q;

endmodule

// ----- hw/rtl/affine_point_transform.sv -----
// ----------------------------------------------------------------------------
// affine_point_transform: 3x4 fixed-point affine transform of 3D points
// Q16.8 points times a Q2.14 matrix plus optional Q16.8 translation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive px_i/py_i/pz_i and raise start; the item is taken at any rising
//   edge where start is high and busy is low. busy stays low: the pipeline
//   takes one item every cycle, back to back.
//   The result qx_o/qy_o/qz_o/overflowed_o is on the ports once the item
//   has left the saturate register, marked by done_o for one cycle,
//   and is taken at the edge that ends that cycle. Stages are
//   input register, multiply, round, sum with translation, saturate; the
//   multiply stage (nine 16x24 multipliers) sets the clock rate.
//   overflowed_o is set when any coordinate was clamped.
//   The receiver cannot stall; results are presented once and not held.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i with no
//   wait; write only while no item is in flight.
//   Reset clears the pipeline valid bits, loads the identity matrix, zero
//   translation and displacement enabled. Items in flight are dropped.
// ----------------------------------------------------------------------------
module affine_point_transform (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [apt_pkg::COORD_W-1:0]    px_i,
  input  logic [apt_pkg::COORD_W-1:0]    py_i,
  input  logic [apt_pkg::COORD_W-1:0]    pz_i,
  output logic                           done_o,
  output logic [apt_pkg::COORD_W-1:0]    qx_o,
  output logic [apt_pkg::COORD_W-1:0]    qy_o,
  output logic [apt_pkg::COORD_W-1:0]    qz_o,
  output logic                           overflowed_o,
  input  logic                           cfg_we_i,
  input  logic [apt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [apt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  apt_pkg::cfg_t                cfg;
  apt_pkg::coord_t [2:0]        point_q;
  logic [apt_pkg::PIPE_DEPTH-1:0] vld_q;
  apt_pkg::coord_t [2:0]        q;
  logic [2:0]                   sat;
  logic                         accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  apt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[apt_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      point_q[0] <= px_i;
      point_q[1] <= py_i;
      point_q[2] <= pz_i;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    apt_row_pipe u_row (
      .clk_i      (clk_i),
      .row_cfg_i  (cfg.row[r]),
      .displace_i (cfg.displace),
      .point_i    (point_q),
      .q_o        (q[r]),
      .sat_o      (sat[r])
    );
  end

  assign done_o       = vld_q[apt_pkg::PIPE_DEPTH-1];
  assign qx_o         = q[0];
  assign qy_o         = q[1];
  assign qz_o         = q[2];
  assign overflowed_o = |sat;

`ifndef NO_ASSERTIONS
  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("accepted item did not come out after pipeline latency");

  // no result without an item accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##5 !done_o)
    else $error("result strobe without accepted item");

  // a clamped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflowed_o) |->
      (q[0] == apt_pkg::COORD_MAX || q[0] == apt_pkg::COORD_MIN ||
       q[1] == apt_pkg::COORD_MAX || q[1] == apt_pkg::COORD_MIN ||
       q[2] == apt_pkg::COORD_MAX || q[2] == apt_pkg::COORD_MIN))
    else $error("overflow flagged but no coordinate at a limit");
`endif

endmodule
